// ===== design/bnms_pkg.sv =====
// Package for the box non-maximum suppression core.
// Holds sizes, box record type and status codes; no dependencies.
package bnms_pkg;
  localparam int MaxBoxes = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int CoordW = 16;
  localparam int ScoreW = 24;
  localparam int AreaW = 34;
  localparam int ThrW = 17;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y2;
    logic signed [CoordW-1:0] x2;
    logic signed [ScoreW-1:0] score;
    logic signed [AreaW-1:0] area;
  } box_t;

  localparam logic [1:0] StUnvisited = 2'd0;
  localparam logic [1:0] StKept = 2'd1;
  localparam logic [1:0] StSuppressed = 2'd2;
endpackage

// ===== design/bnms_cell.sv =====
// One cell of the box chain: holds one box and its status.
// Depends on bnms_pkg.
module bnms_cell (
  input  logic clk,
  input  logic load,          // shift chain by one (load path)
  input  bnms_pkg::box_t box_in,
  input  logic rotate,        // shift chain by one (scan path)
  input  logic [1:0] st_in,
  input  logic valid_in,
  input  logic clear,
  output bnms_pkg::box_t box_out,
  output logic [1:0] st_out,
  output logic valid_out
);
  import bnms_pkg::*;
  box_t box;
  logic [1:0] st;
  logic valid;
  always_ff @(posedge clk) begin
    if (load || rotate) begin
      box <= box_in;
    end
    if (clear) begin
      valid <= 1'b0;
      st <= StUnvisited;
    end else if (load || rotate) begin
      valid <= valid_in;
      st <= st_in;
    end
  end
  assign box_out = box;
  assign st_out = st;
  assign valid_out = valid;
endmodule

// ===== design/box_non_maximum_suppression_core.sv =====
// Top level of the box non-maximum suppression core.
// Depends on bnms_pkg and bnms_cell.
// Boxes are requested one per cycle and shift into a chain of 64 cells.
// A request with tlast starts suppression: the remaining unvisited box with the best
// score is found by one pass around the chain, kept, then a second pass tests it
// against every other unvisited box, one overlap multiply per cycle through a
// three-stage pipe, and a third pass marks it kept. Passes repeat until a search
// pass finds nothing; then one output pass emits the kept boxes, pausing on output
// stalls; the chain rotation sets the pace. No input is taken while a set is being
// processed or emitted.
module box_non_maximum_suppression_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: top[15:0], left[31:16], bottom[47:32], right[63:48], score[87:64]
  input  logic [87:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: box_index[5:0], kept_top[21:6], kept_left[37:22], kept_bottom[53:38],
  //        kept_right[69:54], kept_score[93:70], zero fill [95:94]
  output logic [95:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import bnms_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0, S_FIND = 3'd1, S_SUPP = 3'd2,
                         S_DRAIN = 3'd3, S_EMIT = 3'd4;

  logic [2:0] state;
  logic [ThrW-1:0] thr;
  logic [CntW-1:0] count;
  logic [IdxW-1:0] pos;       // rotations into current pass

  box_t chain_box [MaxBoxes+1];
  logic [1:0] chain_st [MaxBoxes+1];
  logic chain_v [MaxBoxes+1];
  box_t head_box;
  logic [1:0] head_st;
  logic head_v;

  logic load, rotate, clear;
  box_t new_box;
  logic signed [CoordW+1:0] dw, dh;
  logic signed [2*CoordW+3:0] area_full;

  assign dh = {{2{s_axis_tdata[47]}}, s_axis_tdata[47:32]}
              - {{2{s_axis_tdata[15]}}, s_axis_tdata[15:0]} + 18'sd1;
  assign dw = {{2{s_axis_tdata[63]}}, s_axis_tdata[63:48]}
              - {{2{s_axis_tdata[31]}}, s_axis_tdata[31:16]} + 18'sd1;
  assign area_full = dw * dh;
  always_comb begin
    new_box.idx = count[IdxW-1:0];
    new_box.y1 = s_axis_tdata[15:0];
    new_box.x1 = s_axis_tdata[31:16];
    new_box.y2 = s_axis_tdata[47:32];
    new_box.x2 = s_axis_tdata[63:48];
    new_box.score = s_axis_tdata[87:64];
    new_box.area = area_full[AreaW-1:0];
  end

  // last cell feeds the head; rotation sends the head (maybe updated) back to cell 0
  assign head_box = chain_box[MaxBoxes];
  assign head_v = chain_v[MaxBoxes];
  logic [1:0] st_back;
  logic accept_in;
  assign accept_in = s_axis_tvalid && s_axis_tready;
  logic store_in;
  assign store_in = accept_in && (count < CntW'(MaxBoxes));

  assign chain_box[0] = load ? new_box : head_box;
  assign chain_st[0] = load ? StUnvisited : st_back;
  assign chain_v[0] = load ? 1'b1 : head_v;

  genvar g;
  generate
    for (g = 0; g < MaxBoxes; g++) begin : g_cell
      bnms_cell u_cell (
        .clk(clk), .load(load), .box_in(chain_box[g]), .rotate(rotate),
        .st_in(chain_st[g]), .valid_in(chain_v[g]), .clear(clear),
        .box_out(chain_box[g+1]), .st_out(chain_st[g+1]), .valid_out(chain_v[g+1])
      );
    end
  endgenerate
  assign head_st = chain_st[MaxBoxes];

  // hits of the last test pass, applied during the next search pass
  logic [MaxBoxes-1:0] kill;

  // best-box search
  box_t best;
  logic best_found;
  logic head_better;
  assign head_better = head_v && head_st == StUnvisited && !kill[head_box.idx] &&
                       (!best_found || head_box.score > best.score ||
                        (head_box.score == best.score && head_box.idx < best.idx));

  // suppression pipe: stage 1 intersection, stage 2 products, stage 3 compare
  logic signed [CoordW-1:0] yy1, xx1, yy2, xx2;
  assign yy1 = best.y1 > head_box.y1 ? best.y1 : head_box.y1;
  assign xx1 = best.x1 > head_box.x1 ? best.x1 : head_box.x1;
  assign yy2 = best.y2 < head_box.y2 ? best.y2 : head_box.y2;
  assign xx2 = best.x2 < head_box.x2 ? best.x2 : head_box.x2;

  logic cand1, cont1;
  logic signed [CoordW+1:0] w1, h1;
  logic signed [AreaW-1:0] amin1;
  logic [IdxW-1:0] idx1;
  logic cand2, cont2, pos2, zero2, neg2;
  logic [2*(CoordW+1)-1:0] wh2;
  logic [AreaW+ThrW-1:0] ta2;
  logic [IdxW-1:0] idx2;
  logic hit3;
  logic [IdxW-1:0] idx3;

  logic is_cand;
  assign is_cand = head_v && head_st == StUnvisited && head_box.idx != best.idx;

  always_ff @(posedge clk) begin
    cand1 <= state == S_SUPP && is_cand;
    idx1 <= head_box.idx;
    w1 <= {{2{xx2[CoordW-1]}}, xx2} - {{2{xx1[CoordW-1]}}, xx1} + 18'sd1;
    h1 <= {{2{yy2[CoordW-1]}}, yy2} - {{2{yy1[CoordW-1]}}, yy1} + 18'sd1;
    amin1 <= best.area < head_box.area ? best.area : head_box.area;
    cont1 <= (best.y1 < head_box.y1 && best.x1 < head_box.x1 &&
              best.y2 > head_box.y2 && best.x2 > head_box.x2) ||
             (best.y1 > head_box.y1 && best.x1 > head_box.x1 &&
              best.y2 < head_box.y2 && best.x2 < head_box.x2);
    cand2 <= cand1;
    idx2 <= idx1;
    pos2 <= w1 > 18'sd0 && h1 > 18'sd0;
    zero2 <= amin1 == '0;
    neg2 <= amin1 < 0;
    cont2 <= cont1;
    wh2 <= 34'(w1[CoordW:0] * h1[CoordW:0]);
    ta2 <= (AreaW+ThrW)'(thr * amin1[AreaW-2:0]);
    // containment only counts when the boxes do not intersect
    hit3 <= cand2 && (pos2 ? (!neg2 && (zero2 || {wh2, 16'd0} > {1'b0, ta2}))
                           : cont2);
    idx3 <= idx2;
  end

  always_ff @(posedge clk) begin
    if (rst || (state == S_FIND && pos == IdxW'(MaxBoxes-1))) kill <= '0;
    else if (hit3) kill[idx3] <= 1'b1;
  end

  logic [IdxW-1:0] kept_idx;
  always_comb begin
    st_back = head_st;
    if (state == S_FIND && head_v && head_st == StUnvisited && kill[head_box.idx])
      st_back = StSuppressed;
    if (state == S_DRAIN && head_v && head_box.idx == kept_idx && head_st == StUnvisited)
      st_back = StKept;
  end

  // output register
  logic out_full;
  box_t out_box;
  logic out_last;
  logic [IdxW-1:0] last_kept_idx;
  logic emit_hit;
  assign emit_hit = state == S_EMIT && head_v && head_st == StKept;

  assign s_axis_tready = state == S_LOAD;
  assign load = store_in;
  logic stall;
  assign stall = emit_hit && out_full && !m_axis_tready;
  assign rotate = (state == S_FIND || state == S_SUPP || state == S_DRAIN ||
                   state == S_EMIT) && !stall;
  // empty the chain as the output pass ends
  assign clear = rst || (state == S_EMIT && !stall && pos == IdxW'(MaxBoxes-1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      thr <= ThrW'(32768);
      count <= '0;
      pos <= '0;
      best_found <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) out_full <= 1'b0;
      case (state)
        S_LOAD: begin
          if (store_in) count <= count + 1'b1;
          if (accept_in && s_axis_tlast) begin
            state <= S_FIND;
            pos <= '0;
            best_found <= 1'b0;
            last_kept_idx <= '0;
            if (store_in) count <= count + 1'b1;
          end
        end
        S_FIND: begin
          // chain holds count boxes at its far end after loading; invalid cells pass
          if (head_better) begin
            best <= head_box;
            best_found <= 1'b1;
          end
          pos <= pos + 1'b1;
          if (pos == IdxW'(MaxBoxes-1)) begin
            if (best_found || head_better) begin
              state <= S_SUPP;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_SUPP: begin
          kept_idx <= best.idx;
          pos <= pos + 1'b1;
          if (pos == IdxW'(MaxBoxes-1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // one more rotation marks kept; hits land in kill, applied in next FIND
          pos <= pos + 1'b1;
          if (head_v && head_box.idx > last_kept_idx && head_box.idx == kept_idx)
            last_kept_idx <= kept_idx;
          if (pos == IdxW'(MaxBoxes-1)) begin
            state <= S_FIND;
            best_found <= 1'b0;
          end
        end
        S_EMIT: begin
          if (!stall) begin
            if (emit_hit) begin
              out_full <= 1'b1;
              out_box <= head_box;
              out_last <= head_box.idx == last_kept_idx;
            end
            pos <= pos + 1'b1;
            if (pos == IdxW'(MaxBoxes-1)) begin
              state <= S_LOAD;
              count <= '0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = {2'b00, out_box.score, out_box.x2, out_box.y2, out_box.x1,
                         out_box.y1, out_box.idx};
  assign m_axis_tlast = out_last;
endmodule
